// ===== hdl/ddo_pkg.sv =====
// Package for the differential drive odometry block.
// Holds payload types, controller codes, fixed-point constants and helper functions.
// Depends on nothing; every other file of the block imports it.
package ddo_pkg;

  // Sine/cosine iteration count and derived counter width.
  localparam int CORDIC_STEPS = 16;
  localparam int CORD_CNT_W   = $clog2(CORDIC_STEPS);

  // Long division: one quotient bit per cycle over the full dividend.
  localparam int DIV_STEPS = 56;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Fixed-point constants.
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;   // 0.6072529350 in Q1.30
  localparam logic signed [32:0] RAD_TO_BAM  = 33'sd683565276;   // 2^16 / (2 pi) in Q16
  localparam logic signed [32:0] SPEED_SCALE = 33'sd1000000;     // microseconds per second

  // Configuration register indexes.
  localparam logic REG_RADIUS = 1'b0;
  localparam logic REG_TRACK  = 1'b1;

  typedef struct packed {
    logic signed [31:0] left_angle;
    logic signed [31:0] right_angle;
    logic        [31:0] time_us;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        [31:0] heading;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [31:0] linear_speed;
    logic signed [31:0] angular_speed;
    logic               dt_zero;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MUL_DS,
    ST_MUL_DTH,
    ST_DIV_DTH_GO,
    ST_DIV_DTH,
    ST_MUL_BAM,
    ST_HEAD,
    ST_CORD_POS_GO,
    ST_CORD_POS,
    ST_MUL_X,
    ST_MUL_Y,
    ST_ADD_Y,
    ST_CORD_Q,
    ST_MUL_LIN,
    ST_DIV_LIN_GO,
    ST_DIV_LIN,
    ST_MUL_ANG,
    ST_DIV_ANG_GO,
    ST_DIV_ANG,
    ST_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_DS,
    OP_MUL_DTH,
    OP_DIV_DTH_GO,
    OP_DTH_ZERO,
    OP_DTH_TAKE,
    OP_MUL_BAM,
    OP_HEAD,
    OP_CORD_POS_GO,
    OP_MUL_X,
    OP_MUL_Y,
    OP_ADD_Y,
    OP_QUAT,
    OP_MUL_LIN,
    OP_SPD_ZERO,
    OP_DIV_LIN_GO,
    OP_LIN_TAKE,
    OP_MUL_ANG,
    OP_DIV_ANG_GO,
    OP_ANG_TAKE,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic cord_done;
    logic sep_zero;
    logic dt_zero;
  } dp_status_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic [31:0] sat32(input logic signed [66:0] v);
    logic [31:0] r;
    if (v > 67'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (v < -67'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Arctangent of 2^-i as a binary angle.
  function automatic logic [31:0] atan_bam(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/ddo_div.sv =====
// Sequential signed-by-unsigned divider, one quotient bit per cycle.
// Truncates toward zero and clamps the quotient to signed 32 bits.
// Depends on ddo_pkg.
module ddo_div
  import ddo_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [55:0] dividend,
  input  logic        [31:0] divisor,
  output logic               done,
  output logic        [31:0] quotient
);

  logic                 busy;
  logic                 neg;
  logic [DIV_CNT_W-1:0] cnt;
  logic [31:0]          rem;
  logic [31:0]          dsr;
  logic [55:0]          quo;
  logic [32:0]          rem_sh;
  logic                 ge;

  // Shift in the next dividend bit and trial subtract.
  assign rem_sh = {rem, quo[55]};
  assign ge     = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[55];
      quo <= dividend[55] ? 56'(-dividend) : 56'(dividend);
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      rem <= ge ? 32'(rem_sh - {1'b0, dsr}) : rem_sh[31:0];
      quo <= {quo[54:0], ge};
    end
  end

  // Apply the sign and clamp the magnitude.
  always_comb begin
    if (!neg) begin
      quotient = (quo > 56'd2147483647) ? 32'h7fff_ffff : quo[31:0];
    end else begin
      quotient = (quo > 56'd2147483648) ? 32'h8000_0000 : 32'(-quo[31:0]);
    end
  end

endmodule

// ===== hdl/ddo_cordic.sv =====
// Iterative rotation-mode CORDIC: cosine and sine of a binary angle in Q2.30.
// One micro-rotation per cycle.
// Depends on ddo_pkg.
module ddo_cordic
  import ddo_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic        [31:0] angle,
  output logic               done,
  output logic signed [33:0] cos_out,
  output logic signed [33:0] sin_out
);

  logic                  busy;
  logic                  flip;
  logic [CORD_CNT_W-1:0] cnt;
  logic signed [33:0]    x;
  logic signed [33:0]    y;
  logic signed [33:0]    z;
  logic signed [33:0]    xs;
  logic signed [33:0]    ys;
  logic signed [33:0]    at;
  logic                  flip_in;
  logic [31:0]           ang_in;

  // Fold the second and third quadrants onto the first and fourth.
  assign flip_in = angle[31] ^ angle[30];
  assign ang_in  = flip_in ? angle - 32'h8000_0000 : angle;

  assign xs = x >>> cnt;
  assign ys = y >>> cnt;
  assign at = $signed({2'b00, atan_bam(5'(cnt))});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      if (cnt == CORD_CNT_W'(CORDIC_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  // Rotate toward zero residual angle.
  always_ff @(posedge clk) begin
    if (start) begin
      flip <= flip_in;
      x    <= CORDIC_GAIN;
      y    <= '0;
      z    <= 34'($signed(ang_in));
    end else if (busy) begin
      if (!z[33]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
    end
  end

  assign cos_out = flip ? -x : x;
  assign sin_out = flip ? -y : y;

endmodule

// ===== hdl/ddo_datapath.sv =====
// Datapath of the odometry block: state, shared multiplier, divider and CORDIC.
// Acts on one command per cycle from the controller and reports status back.
// Depends on ddo_pkg, ddo_div and ddo_cordic.
module ddo_datapath
  import ddo_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  output dp_status_t  status,
  input  in_item_t    in_data,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [19:0] cfg_data
);

  logic [19:0]        radius_cfg;
  logic [19:0]        track_cfg;
  logic [31:0]        last_left;
  logic [31:0]        last_right;
  logic [31:0]        last_time;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic [31:0]        heading;
  logic signed [33:0] sum_d;
  logic signed [33:0] diff_d;
  logic [31:0]        dt;
  logic               dt_zero;
  logic signed [31:0] ds;
  logic signed [31:0] dth;
  logic signed [31:0] lin;
  logic signed [31:0] ang;
  logic signed [15:0] qz;
  logic signed [15:0] qw;
  logic signed [66:0] p;

  logic signed [33:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [32:0] dl;
  logic signed [32:0] dr;
  logic signed [66:0] bam_full;
  logic signed [66:0] pos_inc;
  logic signed [66:0] px_sum;
  logic signed [66:0] py_sum;

  logic               div_start;
  logic [31:0]        div_divisor;
  logic               div_done;
  logic [31:0]        div_q;
  logic               cord_start;
  logic [31:0]        cord_angle;
  logic               cord_done;
  logic signed [33:0] cord_cos;
  logic signed [33:0] cord_sin;

  // Round a Q2.30 value to Q1.15 with clamping.
  function automatic logic signed [15:0] to_q15(input logic signed [33:0] v);
    logic signed [33:0] t;
    logic signed [15:0] r;
    t = (v + 34'sd16384) >>> 15;
    if (t > 34'sd32767) begin
      r = 16'sh7fff;
    end else if (t < -34'sd32768) begin
      r = -16'sh8000;
    end else begin
      r = t[15:0];
    end
    return r;
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      radius_cfg <= 20'd9175;
      track_cfg  <= 20'd34079;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RADIUS: radius_cfg <= cfg_data;
        REG_TRACK:  track_cfg  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Wheel deltas against the previous sample.
  assign dl = 33'(in_data.left_angle) - 33'($signed(last_left));
  assign dr = 33'(in_data.right_angle) - 33'($signed(last_right));

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = sum_d;
    mul_b = 33'($signed({1'b0, radius_cfg}));
    case (cmd.op)
      OP_MUL_DTH: begin
        mul_a = diff_d;
      end
      OP_MUL_BAM: begin
        mul_a = 34'(dth);
        mul_b = RAD_TO_BAM;
      end
      OP_MUL_X: begin
        mul_a = 34'(ds);
        mul_b = cord_cos[32:0];
      end
      OP_MUL_Y: begin
        mul_a = 34'(ds);
        mul_b = cord_sin[32:0];
      end
      OP_MUL_LIN: begin
        mul_a = 34'(ds);
        mul_b = SPEED_SCALE;
      end
      OP_MUL_ANG: begin
        mul_a = 34'(dth);
        mul_b = SPEED_SCALE;
      end
      default: ;
    endcase
  end

  // Rounded results derived from the product register.
  assign bam_full = p + 67'sd32768;
  assign pos_inc  = (p + 67'sd536870912) >>> 30;
  assign px_sum   = 67'(pose_x) + pos_inc;
  assign py_sum   = 67'(pose_y) + pos_inc;

  // State and pose, sequenced by the command.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_left  <= '0;
      last_right <= '0;
      last_time  <= '0;
      pose_x     <= '0;
      pose_y     <= '0;
      heading    <= '0;
    end else begin
      unique case (cmd.op)
        OP_LOAD: begin
          last_left  <= in_data.left_angle;
          last_right <= in_data.right_angle;
          last_time  <= in_data.time_us;
        end
        OP_HEAD:  heading <= heading + bam_full[47:16];
        OP_MUL_Y: pose_x  <= sat32(px_sum);
        OP_ADD_Y: pose_y  <= sat32(py_sum);
        default: ;
      endcase
    end
  end

  // Working registers of one sample.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_MUL_DS || cmd.op == OP_MUL_DTH || cmd.op == OP_MUL_BAM ||
        cmd.op == OP_MUL_X || cmd.op == OP_MUL_Y || cmd.op == OP_MUL_LIN ||
        cmd.op == OP_MUL_ANG) begin
      p <= mul_a * mul_b;
    end
    unique case (cmd.op)
      OP_LOAD: begin
        sum_d   <= 34'(dr) + 34'(dl);
        diff_d  <= 34'(dr) - 34'(dl);
        dt      <= in_data.time_us - last_time;
        dt_zero <= (in_data.time_us == last_time);
      end
      OP_MUL_DTH:  ds  <= sat32(p >>> 17);
      OP_DTH_ZERO: dth <= '0;
      OP_DTH_TAKE: dth <= div_q;
      OP_QUAT: begin
        qz <= to_q15(cord_sin);
        qw <= to_q15(cord_cos);
      end
      OP_SPD_ZERO: begin
        lin <= '0;
        ang <= '0;
      end
      OP_LIN_TAKE: lin <= div_q;
      OP_ANG_TAKE: ang <= div_q;
      OP_OUT: begin
        out_data.pos_x         <= pose_x;
        out_data.pos_y         <= pose_y;
        out_data.heading       <= heading;
        out_data.quat_z        <= qz;
        out_data.quat_w        <= qw;
        out_data.linear_speed  <= lin;
        out_data.angular_speed <= ang;
        out_data.dt_zero       <= dt_zero;
      end
      default: ;
    endcase
  end

  // Divider hookup: turn-rate divides by separation, speeds by dt.
  assign div_start   = (cmd.op == OP_DIV_DTH_GO) || (cmd.op == OP_DIV_LIN_GO) ||
                       (cmd.op == OP_DIV_ANG_GO);
  assign div_divisor = (cmd.op == OP_DIV_DTH_GO) ? {12'd0, track_cfg} : dt;

  ddo_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (p[55:0]),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // CORDIC runs on the new heading, then on half of it for the quaternion.
  assign cord_start = (cmd.op == OP_CORD_POS_GO) || (cmd.op == OP_ADD_Y);
  assign cord_angle = (cmd.op == OP_ADD_Y) ? {1'b0, heading[31:1]} : heading;

  ddo_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cord_start),
    .angle   (cord_angle),
    .done    (cord_done),
    .cos_out (cord_cos),
    .sin_out (cord_sin)
  );

  assign status.div_done  = div_done;
  assign status.cord_done = cord_done;
  assign status.sep_zero  = (track_cfg == 20'd0);
  assign status.dt_zero   = dt_zero;

endmodule

// ===== hdl/ddo_ctrl.sv =====
// Controller of the odometry block: sequences the datapath per sample.
// Owns the input and output handshakes; talks to the datapath by command and status.
// Depends on ddo_pkg.
module ddo_ctrl
  import ddo_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   load_out;

  assign load_out = (state == ST_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output beat register: held until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:        if (in_valid) state_next = ST_MUL_DS;
      ST_MUL_DS:      state_next = ST_MUL_DTH;
      ST_MUL_DTH:     state_next = ST_DIV_DTH_GO;
      ST_DIV_DTH_GO:  state_next = status.sep_zero ? ST_MUL_BAM : ST_DIV_DTH;
      ST_DIV_DTH:     if (status.div_done) state_next = ST_MUL_BAM;
      ST_MUL_BAM:     state_next = ST_HEAD;
      ST_HEAD:        state_next = ST_CORD_POS_GO;
      ST_CORD_POS_GO: state_next = ST_CORD_POS;
      ST_CORD_POS:    if (status.cord_done) state_next = ST_MUL_X;
      ST_MUL_X:       state_next = ST_MUL_Y;
      ST_MUL_Y:       state_next = ST_ADD_Y;
      ST_ADD_Y:       state_next = ST_CORD_Q;
      ST_CORD_Q:      if (status.cord_done) state_next = ST_MUL_LIN;
      ST_MUL_LIN:     state_next = status.dt_zero ? ST_DONE : ST_DIV_LIN_GO;
      ST_DIV_LIN_GO:  state_next = ST_DIV_LIN;
      ST_DIV_LIN:     if (status.div_done) state_next = ST_MUL_ANG;
      ST_MUL_ANG:     state_next = ST_DIV_ANG_GO;
      ST_DIV_ANG_GO:  state_next = ST_DIV_ANG;
      ST_DIV_ANG:     if (status.div_done) state_next = ST_DONE;
      ST_DONE:        if (load_out) state_next = ST_IDLE;
      default:        state_next = ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    in_ready = 1'b0;
    cmd.op   = OP_NONE;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_LOAD;
      end
      ST_MUL_DS:      cmd.op = OP_MUL_DS;
      ST_MUL_DTH:     cmd.op = OP_MUL_DTH;
      ST_DIV_DTH_GO:  cmd.op = status.sep_zero ? OP_DTH_ZERO : OP_DIV_DTH_GO;
      ST_DIV_DTH:     if (status.div_done) cmd.op = OP_DTH_TAKE;
      ST_MUL_BAM:     cmd.op = OP_MUL_BAM;
      ST_HEAD:        cmd.op = OP_HEAD;
      ST_CORD_POS_GO: cmd.op = OP_CORD_POS_GO;
      ST_CORD_POS:    cmd.op = OP_NONE;
      ST_MUL_X:       cmd.op = OP_MUL_X;
      ST_MUL_Y:       cmd.op = OP_MUL_Y;
      ST_ADD_Y:       cmd.op = OP_ADD_Y;
      ST_CORD_Q:      if (status.cord_done) cmd.op = OP_QUAT;
      ST_MUL_LIN:     cmd.op = status.dt_zero ? OP_SPD_ZERO : OP_MUL_LIN;
      ST_DIV_LIN_GO:  cmd.op = OP_DIV_LIN_GO;
      ST_DIV_LIN:     if (status.div_done) cmd.op = OP_LIN_TAKE;
      ST_MUL_ANG:     cmd.op = OP_MUL_ANG;
      ST_DIV_ANG_GO:  cmd.op = OP_DIV_ANG_GO;
      ST_DIV_ANG:     if (status.div_done) cmd.op = OP_ANG_TAKE;
      ST_DONE:        if (load_out) cmd.op = OP_OUT;
      default:        cmd.op = OP_NONE;
    endcase
  end

endmodule

// ===== hdl/diff_drive_odometry.sv =====
// Differential drive wheel odometry, top level.
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one beat per encoder sample:
//   left and right wheel angles and a microsecond timestamp. Output channel
//   (out_valid/out_ready/out_data) returns one beat per sample: pose, heading,
//   heading quaternion, speeds and the zero-dt flag.
//   The configuration port (cfg_we/cfg_index/cfg_data) sets wheel radius and
//   track width; write it only while no sample is in flight.
// Timing:
//   One sample at a time: a new sample is taken only after the previous one
//   has been loaded into the output register. The time per sample is set
//   mainly by the 56-step long divider, which runs three times (turn rate,
//   linear speed, angular speed), and the two 16-step CORDIC passes. With
//   zero dt the speed divisions are skipped; with zero separation the
//   turn-rate division is skipped.
// Reset: clears pose, heading and the previous sample; restores default
//   wheel geometry; the output channel goes idle.
// Stall: a finished beat is held in the output register; the next sample can
//   be accepted and processed meanwhile, and its result waits until the held
//   beat is taken.
// Depends on ddo_pkg, ddo_ctrl and ddo_datapath.
module diff_drive_odometry
  import ddo_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [19:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  ddo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  ddo_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

// ===== hdl/ddo_checker.sv =====
// Port-level checker for the odometry block, bound to the top level.
// Watches the handshakes and output beats over time.
// Depends on ddo_pkg and diff_drive_odometry.
module ddo_port_checker
  import ddo_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A stalled output beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  // A stalled output beat keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("output payload changed while stalled");

  // One sample at a time: the block goes busy after taking a beat.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a sample is in flight");

  // Zero elapsed time forces both speeds to zero.
  a_dt_zero_speeds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.dt_zero |->
      out_data.linear_speed == 32'sd0 && out_data.angular_speed == 32'sd0)
    else $error("nonzero speed reported with zero dt");

  // Reset empties the output register.
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind diff_drive_odometry ddo_port_checker u_ddo_port_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== bench/ddo_checker.sv =====
// Checker for the differential drive odometry block: watches both channels,
// predicts each output beat from the accepted input beats and compares.
// Depends on ddo_pkg for the payload types and fixed-point constants.
`timescale 1ns / 100ps

module ddo_checker
  import ddo_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [19:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  // Geometry and odometry state as the block should hold it.
  logic [19:0]        radius_q;
  logic [19:0]        separation_q;
  logic [31:0]        prev_left;
  logic [31:0]        prev_right;
  logic [31:0]        prev_time;
  logic signed [63:0] odo_x;
  logic signed [63:0] odo_y;
  logic [31:0]        odo_heading;

  out_item_t pose_queue[$];

  // Floor division by a power of two.
  function automatic logic signed [127:0] shr_floor(input logic signed [127:0] v,
                                                    input int s);
    return v >>> s;
  endfunction

  function automatic logic signed [63:0] clamp32(input logic signed [127:0] v);
    if (v > 128'sd2147483647) return 64'sd2147483647;
    if (v < -128'sd2147483648) return -64'sd2147483648;
    return v[63:0];
  endfunction

  function automatic logic signed [15:0] to_q15(input logic signed [63:0] v);
    logic signed [127:0] r;
    r = shr_floor(128'(v) + 128'sd16384, 15);
    if (r > 128'sd32767) return 16'sh7fff;
    if (r < -128'sd32768) return 16'sh8000;
    return r[15:0];
  endfunction

  // CORDIC rotation with its own arctangent table, Q2.30 results.
  task automatic rotate_bam(input logic [31:0] ang, output logic signed [63:0] c,
                            output logic signed [63:0] s);
    logic signed [63:0] atan_tab[32];
    logic signed [63:0] x, y, z, t;
    logic flip;
    atan_tab = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
                 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
                 64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
                 64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
                 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
                 64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001,
                 64'h00000001, 64'h00000000};
    flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
    if (flip) ang = ang - 32'h8000_0000;
    x = 64'(CORDIC_GAIN);
    y = 0;
    z = 64'(signed'(ang));
    for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z = z - atan_tab[i];
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z = z + atan_tab[i];
      end
      x = t;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = x;
    s = y;
  endtask

  // Advance the pose by one encoder sample and return the expected beat.
  task automatic integrate_sample(input in_item_t smp, output out_item_t res);
    logic signed [127:0] dl, dr, r, ds, dth, prod;
    logic signed [63:0] c, s;
    logic [31:0] dt, dbam;
    dl = 128'(smp.left_angle) - 128'(signed'(prev_left));
    dr = 128'(smp.right_angle) - 128'(signed'(prev_right));
    dt = smp.time_us - prev_time;
    r = 128'(radius_q);
    prev_left = smp.left_angle;
    prev_right = smp.right_angle;
    prev_time = smp.time_us;
    ds = clamp32(shr_floor(r * (dr + dl), 17));
    dth = 0;
    if (separation_q != 0)
      dth = clamp32((r * (dr - dl)) / $signed(128'(separation_q)));
    prod = shr_floor(dth * 128'sd683565276 + 128'sd32768, 16);
    dbam = prod[31:0];
    odo_heading = odo_heading + dbam;
    rotate_bam(odo_heading, c, s);
    odo_x = clamp32(128'(odo_x) + shr_floor(ds * 128'(c) + (128'sd1 <<< 29), 30));
    odo_y = clamp32(128'(odo_y) + shr_floor(ds * 128'(s) + (128'sd1 <<< 29), 30));
    res.pos_x = odo_x[31:0];
    res.pos_y = odo_y[31:0];
    res.heading = odo_heading;
    res.linear_speed = '0;
    res.angular_speed = '0;
    res.dt_zero = (dt == 0);
    if (dt != 0) begin
      res.linear_speed = 32'(clamp32((ds * 128'sd1000000) / $signed(128'(dt))));
      res.angular_speed = 32'(clamp32((dth * 128'sd1000000) / $signed(128'(dt))));
    end
    rotate_bam(odo_heading >> 1, c, s);
    res.quat_z = to_q15(s);
    res.quat_w = to_q15(c);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] %s: got %h, want %h", $realtime, what, got, want);
    fail_count++;
  endtask

  // Track configuration, predict on each input beat, compare each output beat.
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (rst) begin
      radius_q <= 20'd9175;
      separation_q <= 20'd34079;
      prev_left = '0;
      prev_right = '0;
      prev_time = '0;
      odo_x = '0;
      odo_y = '0;
      odo_heading = '0;
      pose_queue.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_RADIUS) radius_q <= cfg_data;
        else separation_q <= cfg_data;
      end
      if (in_valid && in_ready) begin
        integrate_sample(in_data, want);
        pose_queue.push_back(want);
      end
      if (out_valid && out_ready) begin
        got = out_data;
        if (pose_queue.size() == 0) begin
          report_mismatch("beat with nothing expected", got.heading, '0);
        end else begin
          want = pose_queue.pop_front();
          if (got.pos_x !== want.pos_x) report_mismatch("pos_x", got.pos_x, want.pos_x);
          if (got.pos_y !== want.pos_y) report_mismatch("pos_y", got.pos_y, want.pos_y);
          if (got.heading !== want.heading)
            report_mismatch("heading", got.heading, want.heading);
          if (got.quat_z !== want.quat_z)
            report_mismatch("quat_z", 32'(got.quat_z), 32'(want.quat_z));
          if (got.quat_w !== want.quat_w)
            report_mismatch("quat_w", 32'(got.quat_w), 32'(want.quat_w));
          if (got.linear_speed !== want.linear_speed)
            report_mismatch("linear_speed", got.linear_speed, want.linear_speed);
          if (got.angular_speed !== want.angular_speed)
            report_mismatch("angular_speed", got.angular_speed, want.angular_speed);
          if (got.dt_zero !== want.dt_zero)
            report_mismatch("dt_zero", 32'(got.dt_zero), 32'(want.dt_zero));
        end
      end
    end
    pending = pose_queue.size();
  end

endmodule

// ===== bench/tb_diff_drive_odometry.sv =====
// Testbench top for the differential drive odometry block: drives samples,
// geometry writes and output back-pressure; ddo_checker does the comparing.
// Depends on ddo_pkg, ddo_checker and the block's RTL.
`timescale 1ns / 100ps

module tb_diff_drive_odometry;
  import ddo_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_RADIUS;
  logic [19:0] cfg_data = '0;
  int          fail_count;
  int          pending;

  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_off_cycles = 0;
  logic [31:0] clock_us = 0;
  logic signed [31:0] left_pos = 0;
  logic signed [31:0] right_pos = 0;

  always #6 clk = ~clk;

  diff_drive_odometry DUT (.*);

  ddo_checker u_checker (.*);

  // Output back-pressure: random stalls, or a long hold-off when asked.
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Present one sample and wait for its input beat; valid stays up afterwards
  // until the next sample or a drain takes it down.
  task automatic send_sample(input logic [31:0] l, input logic [31:0] r,
                             input logic [31:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{left_angle: l, right_angle: r, time_us: t};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Everything in flight drains, then a little slack for the block's tail.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_geometry(input logic idx, input logic [19:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly plausible motion, some wild jumps and repeated timestamps.
  task automatic random_motion(input int count);
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(9))
        0: begin
          left_pos = $urandom;
          right_pos = $urandom;
          clock_us = clock_us + $urandom;
        end
        1: clock_us = clock_us;
        default: begin
          left_pos = left_pos + $signed(32'($urandom_range(2 ** 18))) - (2 ** 17);
          right_pos = right_pos + $signed(32'($urandom_range(2 ** 18))) - (2 ** 17);
          clock_us = clock_us + $urandom_range(20000);
        end
      endcase
      send_sample(left_pos, right_pos, clock_us);
    end
  endtask

  initial begin
    #20_000_000;
    $display("diff_drive_odometry: mismatch");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, zero dt, first-sample deltas, large turns.
    send_sample(32'h0001_0000, 32'h0002_0000, 32'd1000);
    send_sample(32'h0001_0000, 32'h0002_0000, 32'd1000);
    send_sample(32'h7fff_ffff, 32'h8000_0000, 32'd1001);
    send_sample(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
    send_sample(32'h7fff_ffff, 32'h7fff_ffff, 32'd0);
    send_sample(32'h8000_0000, 32'h8000_0000, 32'd1);
    send_sample(32'h0, 32'h0, 32'h8000_0000);
    send_sample(32'h0100_0000, 32'hff00_0000, 32'h8000_0001);
    send_sample(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555);
    send_sample(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);
    drain();
    write_geometry(REG_RADIUS, 20'hfffff);
    write_geometry(REG_TRACK, 20'd1);
    send_sample(32'h7fff_ffff, 32'h8000_0000, 32'd5);
    send_sample(32'h0000_1000, 32'h0000_3000, 32'd6);
    send_sample(32'h0000_1000, 32'h0000_3000, 32'd6);
    drain();
    write_geometry(REG_TRACK, 20'd0);
    send_sample(32'h0010_0000, 32'h0030_0000, 32'd100);
    drain();
    write_geometry(REG_RADIUS, 20'd0);
    write_geometry(REG_TRACK, 20'hfffff);
    send_sample(32'h1234_5678, 32'h8765_4321, 32'd200);
    drain();

    // Random phases over several geometries and idling mixes.
    left_pos = 32'h8765_4321;
    right_pos = 32'h1234_5678;
    clock_us = 32'd200;
    for (int ph = 0; ph < 8; ph++) begin
      write_geometry(REG_RADIUS, (ph == 7) ? 20'd1 : 20'($urandom_range(1, 2 ** 20 - 1)));
      write_geometry(REG_TRACK,
                     (ph == 6) ? 20'hfffff : 20'($urandom_range(1, 2 ** 20 - 1)));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      if (ph == 2) hold_off_cycles = 1500;
      random_motion(115);
      drain();
    end
    write_geometry(REG_RADIUS, 20'd9175);
    write_geometry(REG_TRACK, 20'd34079);
    send_idle_pct = 10;
    recv_stall_pct = 10;
    random_motion(20);

    drain();
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("diff_drive_odometry: match");
    end else begin
      $display("diff_drive_odometry: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/ddo_pkg.sv
hdl/ddo_div.sv
hdl/ddo_cordic.sv
hdl/ddo_datapath.sv
hdl/ddo_ctrl.sv
hdl/diff_drive_odometry.sv
hdl/ddo_checker.sv
bench/ddo_checker.sv
bench/tb_diff_drive_odometry.sv
